>>> rtl/core/hev_pkg.sv
package hev_pkg;

    // Field widths of the encoder.
    localparam int DATA_W       = 57;
    localparam int CODE_W       = 63;
    localparam int LEN_W        = 6;
    localparam int PAR_W        = 3;
    localparam int NUM_PAR      = 6;

    // Longest message whose code still fits in CODE_W bits, and the reset length.
    localparam int MAX_DATA_LEN = 57;
    localparam int LEN_RESET    = 4;

    // Lengths derived from the configured message length.
    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic [LEN_W-1:0] n;
        logic [PAR_W-1:0] r;
    } t_len_info;

    // One word in flight between pipeline stages.
    typedef struct packed {
        logic              valid;
        logic [CODE_W-1:0] cw;
        logic [LEN_W-1:0]  n;
        logic [PAR_W-1:0]  r;
    } t_stage;

endpackage

>>> rtl/core/hev_cfg.sv
module hev_cfg (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [hev_pkg::LEN_W-1:0] i_cfg_data,
    output hev_pkg::t_len_info       o_info
);

    logic [hev_pkg::LEN_W-1:0] r_data_len;
    logic [hev_pkg::LEN_W-1:0] sat_len;
    logic [hev_pkg::PAR_W-1:0] par_cnt;

    // Message length register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data_len <= hev_pkg::LEN_W'(hev_pkg::LEN_RESET);
        end else if (i_cfg_we) begin
            r_data_len <= i_cfg_data;
        end
    end

    // Saturate the length so the code fits, then pick the fewest parity bits.
    always_comb begin
        if (r_data_len > hev_pkg::LEN_W'(hev_pkg::MAX_DATA_LEN)) begin
            sat_len = hev_pkg::LEN_W'(hev_pkg::MAX_DATA_LEN);
        end else begin
            sat_len = r_data_len;
        end

        priority if (sat_len == '0) begin
            par_cnt = 3'd0;
        end else if (sat_len == 6'd1) begin
            par_cnt = 3'd2;
        end else if (sat_len <= 6'd4) begin
            par_cnt = 3'd3;
        end else if (sat_len <= 6'd11) begin
            par_cnt = 3'd4;
        end else if (sat_len <= 6'd26) begin
            par_cnt = 3'd5;
        end else begin
            par_cnt = 3'd6;
        end

        o_info.len = sat_len;
        o_info.r   = par_cnt;
        o_info.n   = sat_len + hev_pkg::LEN_W'(par_cnt);
    end

endmodule

>>> rtl/core/hev_spread.sv
module hev_spread (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  logic [hev_pkg::DATA_W-1:0] i_data_word,
    input  hev_pkg::t_len_info        i_info,
    output hev_pkg::t_stage           o_stage
);

    logic [hev_pkg::DATA_W-1:0] mask;
    logic [hev_pkg::DATA_W-1:0] masked;
    logic [hev_pkg::CODE_W-1:0] n_cw;

    logic                       r_valid;
    logic [hev_pkg::CODE_W-1:0] r_cw;
    logic [hev_pkg::LEN_W-1:0]  r_n;
    logic [hev_pkg::PAR_W-1:0]  r_r;

    // Keep only the message bits, then drop them into the non-power-of-two positions.
    always_comb begin
        int j;
        j      = 0;
        mask   = ~({hev_pkg::DATA_W{1'b1}} << i_info.len);
        masked = i_data_word & mask;
        n_cw   = '0;
        for (int pos = 1; pos <= hev_pkg::CODE_W; pos++) begin
            if ((pos & (pos - 1)) != 0) begin
                n_cw[pos-1] = masked[j];
                j++;
            end
        end
    end

    // Stage one valid bit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    // Stage one payload.
    always_ff @(posedge i_clk) begin
        r_cw <= n_cw;
        r_n  <= i_info.n;
        r_r  <= i_info.r;
    end

    assign o_stage.valid = r_valid;
    assign o_stage.cw    = r_cw;
    assign o_stage.n     = r_n;
    assign o_stage.r     = r_r;

endmodule

>>> rtl/core/hev_parity.sv
module hev_parity (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  hev_pkg::t_stage            i_stage,
    output hev_pkg::t_stage            o_stage,
    output logic [hev_pkg::NUM_PAR-1:0] o_par
);

    logic [hev_pkg::NUM_PAR-1:0] n_par;

    logic                        r_valid;
    logic [hev_pkg::CODE_W-1:0]  r_cw;
    logic [hev_pkg::LEN_W-1:0]   r_n;
    logic [hev_pkg::PAR_W-1:0]   r_r;
    logic [hev_pkg::NUM_PAR-1:0] r_par;

    // Positions covered by parity bit p: every index with bit p set.
    function automatic logic [hev_pkg::CODE_W-1:0] cover_mask(input int p);
        logic [hev_pkg::CODE_W-1:0] m;
        m = '0;
        for (int k = 1; k <= hev_pkg::CODE_W; k++) begin
            if (((k >> p) & 1) == 1) begin
                m[k-1] = 1'b1;
            end
        end
        return m;
    endfunction

    // Even parity trees. Data past the code length is already zero, so
    // parity bits beyond the parity count come out zero as well.
    always_comb begin
        for (int p = 0; p < hev_pkg::NUM_PAR; p++) begin
            n_par[p] = ^(i_stage.cw & cover_mask(p));
        end
    end

    // Stage two valid bit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_stage.valid;
        end
    end

    // Stage two payload.
    always_ff @(posedge i_clk) begin
        r_cw  <= i_stage.cw;
        r_n   <= i_stage.n;
        r_r   <= i_stage.r;
        r_par <= n_par;
    end

    assign o_stage.valid = r_valid;
    assign o_stage.cw    = r_cw;
    assign o_stage.n     = r_n;
    assign o_stage.r     = r_r;
    assign o_par         = r_par;

endmodule

>>> rtl/core/hamming_encoder_variable_length_core.sv
// Even-parity Hamming encoder for messages of 1 to 57 bits. A word is taken
// at each clock edge where start is high; busy is never raised, so a new word
// may come every cycle. Its result appears on the o_ ports with o_valid high
// for one cycle, once it has passed the three register stages (message mask
// and bit placement, parity trees, output).
// The receiver cannot stall and must take each result in that cycle. The
// message length register may only be written while no word is in flight;
// lengths above 57 are treated as 57, and a length of 0 gives an all-zero result.
module hamming_encoder_variable_length_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       i_cfg_we,
    input  logic [hev_pkg::LEN_W-1:0]  i_cfg_data,
    input  logic [hev_pkg::DATA_W-1:0] i_data_word,
    output logic                       o_valid,
    output logic [hev_pkg::CODE_W-1:0] o_codeword,
    output logic [hev_pkg::LEN_W-1:0]  o_code_length,
    output logic [hev_pkg::PAR_W-1:0]  o_parity_count
);

    hev_pkg::t_len_info          info;
    hev_pkg::t_stage             s1;
    hev_pkg::t_stage             s2;
    logic [hev_pkg::NUM_PAR-1:0] s2_par;
    logic [hev_pkg::CODE_W-1:0]  n_codeword;

    logic                        r_valid;
    logic [hev_pkg::CODE_W-1:0]  r_codeword;
    logic [hev_pkg::LEN_W-1:0]   r_code_length;
    logic [hev_pkg::PAR_W-1:0]   r_parity_count;

    // The pipeline never backs up.
    assign busy = 1'b0;

    hev_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_info     (info)
    );

    hev_spread u_spread (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (start & ~busy),
        .i_data_word (i_data_word),
        .i_info      (info),
        .o_stage     (s1)
    );

    hev_parity u_parity (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stage (s1),
        .o_stage (s2),
        .o_par   (s2_par)
    );

    // Insert the parity bits at the power-of-two positions.
    always_comb begin
        n_codeword = s2.cw;
        for (int p = 0; p < hev_pkg::NUM_PAR; p++) begin
            n_codeword[(1 << p) - 1] = s2_par[p];
        end
    end

    // Output strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= s2.valid;
        end
    end

    // Output word.
    always_ff @(posedge i_clk) begin
        r_codeword     <= n_codeword;
        r_code_length  <= s2.n;
        r_parity_count <= s2.r;
    end

    assign o_valid        = r_valid;
    assign o_codeword     = r_codeword;
    assign o_code_length  = r_code_length;
    assign o_parity_count = r_parity_count;

    // Every result comes from an earlier word taken on start.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, 3))
        else $error("result without a word taken three cycles earlier");

    // A taken word reaches the first stage.
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |=> s1.valid)
        else $error("taken word lost at the first stage");

    // Nothing is set above the code length.
    a_upper_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_codeword >> o_code_length) == '0))
        else $error("codeword bits set above the code length");

    // The code length covers the parity bits.
    a_len_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_code_length >= hev_pkg::LEN_W'(o_parity_count)))
        else $error("code length below parity count");

endmodule
